/* sv/adfmt_pkg.sv */
// adfmt_pkg: shared types and constants for the autorange decimal display formatter
// used by adfmt_ctrl, adfmt_dp and autorange_decimal_display_format
package adfmt_pkg;

  localparam int MeasW   = 32;
  localparam int ProdW   = 64;
  localparam int CharW   = 7;
  localparam int PrefixW = 3;
  localparam int StatW   = 2;
  localparam int DecW    = 3;
  localparam int InW     = 40;
  localparam int OutW    = 56;
  localparam int CfgIdxW = 2;

  localparam logic [ProdW-1:0] DisplayMax = 64'd999999;
  localparam logic [PrefixW-1:0] PrefixGiga    = 3'd3;
  localparam logic [PrefixW-1:0] PrefixUnknown = 3'd4;

  localparam logic [CfgIdxW-1:0] RegMult  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDiv   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStart = 2'd2;

  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatDigit   = 2'd1;
  localparam logic [StatW-1:0] StatPrefix  = 2'd2;
  localparam logic [StatW-1:0] StatBadPt   = 2'd3;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChBlank = 7'h20;
  localparam logic [CharW-1:0] ChPoint = 7'h2e;
  localparam logic [CharW-1:0] ChX     = 7'h58;
  localparam logic [CharW-1:0] ChStar  = 7'h2a;
  localparam logic [CharW-1:0] ChBang  = 7'h21;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL,
    CMD_DIVSTEP,
    CMD_CHK,
    CMD_TENSTEP,
    CMD_SCALE,
    CMD_DIGIT,
    CMD_FMT
  } cmd_t;

  typedef struct packed {
    logic over;
    logic err;
    logic out_busy;
  } dp_status_t;

endpackage

/* sv/adfmt_ctrl.sv */
// adfmt_ctrl: sequencer for load, multiply, long division, scaling and digit extraction
// depends on adfmt_pkg
module adfmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  adfmt_pkg::dp_status_t st,
  output adfmt_pkg::cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_TEN   = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_DIG   = 8'b0100_0000,
    S_FMT   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [2:0] dcnt, dcnt_next;
  logic       digmode, digmode_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dcnt_next    = dcnt;
    digmode_next = digmode;
    cmd          = adfmt_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = adfmt_pkg::CMD_LOAD;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd        = adfmt_pkg::CMD_MUL;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd      = adfmt_pkg::CMD_DIVSTEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) state_next = S_CHK;
      end
      S_CHK: begin
        cmd      = adfmt_pkg::CMD_CHK;
        cnt_next = '0;
        if (st.over && !st.err) begin
          digmode_next = 1'b0;
        end else begin
          digmode_next = 1'b1;
          dcnt_next    = '0;
        end
        state_next = S_TEN;
      end
      S_TEN: begin
        cmd      = adfmt_pkg::CMD_TENSTEP;
        cnt_next = cnt + 6'd1;
        if (cnt[2:0] == 3'd7) state_next = digmode ? S_DIG : S_SCALE;
      end
      S_SCALE: begin
        cmd        = adfmt_pkg::CMD_SCALE;
        state_next = S_CHK;
      end
      S_DIG: begin
        cmd       = adfmt_pkg::CMD_DIGIT;
        cnt_next  = '0;
        dcnt_next = dcnt + 3'd1;
        state_next = (dcnt == 3'd5) ? S_FMT : S_TEN;
      end
      S_FMT: begin
        if (!st.out_busy) begin
          cmd        = adfmt_pkg::CMD_FMT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      dcnt    <= '0;
      digmode <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dcnt    <= dcnt_next;
      digmode <= digmode_next;
    end
  end

endmodule

/* sv/adfmt_dp.sv */
// adfmt_dp: registers, multiplier, shift divider, divide-by-ten unit and output formatting
// depends on adfmt_pkg
module adfmt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  adfmt_pkg::cmd_t             cmd,
  output adfmt_pkg::dp_status_t       st,
  input  logic [adfmt_pkg::InW-1:0]   in_data,
  input  logic                        cfg_we,
  input  logic [adfmt_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [31:0]                 cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [adfmt_pkg::OutW-1:0]  out_data
);

  logic [31:0] mult, divisor;
  logic [adfmt_pkg::DecW-1:0] start_dec;
  logic [31:0] meas;
  logic [63:0] v;
  logic [31:0] rem;
  logic [adfmt_pkg::DecW-1:0] dec;
  logic [adfmt_pkg::PrefixW-1:0] prefix;
  logic [adfmt_pkg::StatW-1:0] stat;
  logic [3:0] dig [6];

  // one restoring step of the long division
  logic [31:0] div_eff;
  logic [32:0] dtrial;
  always_comb begin
    div_eff = (divisor == '0) ? 32'd1 : divisor;
    dtrial  = {rem, v[63]};
  end

  // eight bits of divide by ten per cycle
  logic [63:0] tv;
  logic [3:0]  tr;
  always_comb begin
    logic [4:0] t;
    tv = v;
    tr = rem[3:0];
    for (int k = 0; k < 8; k++) begin
      t  = {tr, tv[63]};
      tv = {tv[62:0], 1'b0};
      if (t >= 5'd10) begin
        tr    = 4'(t - 5'd10);
        tv[0] = 1'b1;
      end else begin
        tr = t[3:0];
      end
    end
  end

  // display columns from the extracted digits
  logic [6:0] cols [7];
  logic [adfmt_pkg::StatW-1:0] fstat;
  logic [adfmt_pkg::PrefixW-1:0] fprefix;
  always_comb begin
    logic [6:0] c0, c1, d3c;
    logic lead;
    fstat = stat;
    if (stat == adfmt_pkg::StatOk && (dec < 3'd1 || dec > 3'd3)) fstat = adfmt_pkg::StatBadPt;
    lead = (dig[5] != 4'd0) || (dec == 3'd1);
    c0 = lead ? (adfmt_pkg::ChZero + 7'(dig[5])) : adfmt_pkg::ChBlank;
    c1 = ((dig[4] != 4'd0) || dec == 3'd2 || lead) ? (adfmt_pkg::ChZero + 7'(dig[4]))
                                                    : adfmt_pkg::ChBlank;
    d3c = adfmt_pkg::ChZero + 7'(dig[3]);
    cols[0] = c0;
    cols[4] = adfmt_pkg::ChZero + 7'(dig[2]);
    cols[5] = adfmt_pkg::ChZero + 7'(dig[1]);
    cols[6] = adfmt_pkg::ChZero + 7'(dig[0]);
    if (dec == 3'd1) begin
      cols[1] = adfmt_pkg::ChPoint; cols[2] = c1; cols[3] = d3c;
    end else if (dec == 3'd2) begin
      cols[1] = c1; cols[2] = adfmt_pkg::ChPoint; cols[3] = d3c;
    end else begin
      cols[1] = c1; cols[2] = d3c; cols[3] = adfmt_pkg::ChPoint;
    end
    fprefix = prefix;
    unique case (fstat)
      adfmt_pkg::StatOk: ;
      adfmt_pkg::StatDigit: begin
        for (int i = 0; i < 7; i++) cols[i] = adfmt_pkg::ChX;
        fprefix = '0;
      end
      adfmt_pkg::StatPrefix: begin
        for (int i = 0; i < 7; i++) cols[i] = adfmt_pkg::ChStar;
        cols[3] = adfmt_pkg::ChPoint;
      end
      adfmt_pkg::StatBadPt: begin
        for (int i = 0; i < 7; i++) cols[i] = adfmt_pkg::ChBang;
        fprefix = '0;
      end
      default: ;
    endcase
  end

  assign st.over     = (v > adfmt_pkg::DisplayMax);
  assign st.err      = (stat != adfmt_pkg::StatOk);
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult      <= 32'd1;
      divisor   <= 32'd1;
      start_dec <= 3'd3;
    end else if (cfg_we) begin
      priority case (cfg_idx)
        adfmt_pkg::RegMult:  mult      <= cfg_wdata;
        adfmt_pkg::RegDiv:   divisor   <= cfg_wdata;
        adfmt_pkg::RegStart: start_dec <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      adfmt_pkg::CMD_LOAD: begin
        meas   <= in_data[31:0];
        prefix <= (in_data[34:32] > adfmt_pkg::PrefixUnknown) ? adfmt_pkg::PrefixUnknown
                                                             : in_data[34:32];
        dec    <= start_dec;
        stat   <= adfmt_pkg::StatOk;
      end
      adfmt_pkg::CMD_MUL: begin
        v   <= 64'(meas) * 64'(mult);
        rem <= '0;
      end
      adfmt_pkg::CMD_DIVSTEP: begin
        if (dtrial >= {1'b0, div_eff}) begin
          rem <= 32'(dtrial - {1'b0, div_eff});
          v   <= {v[62:0], 1'b1};
        end else begin
          rem <= dtrial[31:0];
          v   <= {v[62:0], 1'b0};
        end
      end
      adfmt_pkg::CMD_CHK: rem <= '0;
      adfmt_pkg::CMD_TENSTEP: begin
        v   <= tv;
        rem <= {28'd0, tr};
      end
      adfmt_pkg::CMD_SCALE: begin
        if (dec == 3'd1 || dec == 3'd2) begin
          dec <= dec + 3'd1;
        end else if (dec == 3'd3) begin
          dec <= 3'd1;
          if (prefix < adfmt_pkg::PrefixGiga) prefix <= prefix + 3'd1;
          else stat <= adfmt_pkg::StatPrefix;
        end else begin
          stat <= adfmt_pkg::StatDigit;
        end
      end
      adfmt_pkg::CMD_DIGIT: begin
        // least significant digit comes first and ends in dig[0]
        dig[5] <= rem[3:0];
        for (int i = 0; i < 5; i++) dig[i] <= dig[i+1];
        rem <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == adfmt_pkg::CMD_FMT) begin
      out_data <= {2'b00, fstat, fprefix, cols[6], cols[5], cols[4], cols[3], cols[2],
                   cols[1], cols[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd == adfmt_pkg::CMD_FMT) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule

/* sv/autorange_decimal_display_format.sv */
// autorange_decimal_display_format: top level of the autoranging display formatter
// depends on adfmt_pkg, adfmt_ctrl, adfmt_dp
//
// usage: one beat on s_axis carries a 32-bit measurement and a unit prefix. the block
// scales it by multiplier/divisor, autoranges it below one million by steps of ten
// while moving the decimal point and prefix, and sends one beat on m_axis with seven
// ascii columns, the resulting prefix and a status code.
// cfg_* writes the calibration registers (0 multiplier, 1 divisor, 2 start decimals);
// it is always ready; the user must write it only while the block is idle; not enforced.
// sequence: load, multiply, a 64-step restoring division (one quotient bit a cycle),
// then per range step a check, a divide by ten at eight bits a cycle and an update,
// then a final check, six digits each taken by a divide by ten, then the output register.
// s_tready is high only while the sequencer is idle. the output register holds a
// finished beat while m_tready is low; a new item can be taken meanwhile but its
// result waits until the register is free.
// reset (rst, synchronous) returns the sequencer to idle, drops m_tvalid and restores
// multiplier 1, divisor 1, start decimals 3.
module autorange_decimal_display_format (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // measurement[31:0], prefix_in[34:32], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // char_0..char_6 7 bits each, prefix_out, status, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  adfmt_pkg::cmd_t       cmd;
  adfmt_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  adfmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  adfmt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
